// File: hdl/cpcl_pkg.sv
`default_nettype none
package cpcl_pkg;
   localparam int MotorCountDefault = 4;
   localparam int CmdWidth          = 15;
   localparam int LimitWidth        = 16;
   localparam int PowerWidth        = 14;
   localparam int BufferWidth       = 8;
   localparam int CsrAddrWidth      = 1;
   localparam int CsrDataWidth      = 8;
   localparam logic [CsrAddrWidth-1:0] CSR_WARN_LEVEL    = 1'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_POWER_LIMIT_W = 1'd1;
   localparam logic [16:0] LIMIT_NO_REFEREE = 17'd64000;
   localparam logic [16:0] LIMIT_BUFFER     = 17'd16000;
   localparam logic [16:0] LIMIT_POWER      = 17'd20000;
   localparam logic [7:0]  WARN_BUFFER_J    = 8'd55;
   localparam logic [7:0]  MIN_BUFFER_J     = 8'd5;
   localparam int QuotWidth = 17;

   function automatic logic [7:0] warn_power(input logic [1:0] level);
      case (level)
         2'd2:    warn_power = 8'd50;
         2'd3:    warn_power = 8'd60;
         default: warn_power = 8'd40;
      endcase
   endfunction
endpackage
`default_nettype wire

// File: hdl/cpcl_req_if.sv
`default_nettype none
interface cpcl_req_if #(parameter int MOTOR_COUNT = cpcl_pkg::MotorCountDefault);
   logic valid;
   logic ready;
   logic referee_ok;
   logic [cpcl_pkg::PowerWidth-1:0] chassis_power_q6;
   logic [cpcl_pkg::BufferWidth-1:0] buffer_energy;
   logic signed [cpcl_pkg::CmdWidth-1:0] motor_cmd [MOTOR_COUNT];
   modport source (output valid, referee_ok, chassis_power_q6, buffer_energy, motor_cmd,
                   input ready);
   modport sink (input valid, referee_ok, chassis_power_q6, buffer_energy, motor_cmd,
                 output ready);
endinterface
`default_nettype wire

// File: hdl/cpcl_rsp_if.sv
`default_nettype none
interface cpcl_rsp_if #(parameter int MOTOR_COUNT = cpcl_pkg::MotorCountDefault);
   logic valid;
   logic ready;
   logic signed [cpcl_pkg::CmdWidth-1:0] drive [MOTOR_COUNT];
   logic [cpcl_pkg::LimitWidth-1:0] current_limit;
   logic was_scaled;
   modport source (output valid, drive, current_limit, was_scaled, input ready);
   modport sink (input valid, drive, current_limit, was_scaled, output ready);
endinterface
`default_nettype wire

// File: hdl/cpcl_div.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage. Valid bits and a
// tag travel alongside; the whole pipe advances when en is high.
module cpcl_div #(
   parameter int NW = 32,
   parameter int DW = 20,
   parameter int QW = 17,
   parameter int TW = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [NW-1:0] in_num,
   input  wire logic [DW-1:0] in_den,
   input  wire logic [TW-1:0] in_tag,
   output logic               out_valid,
   output logic [QW-1:0]      out_quot,
   output logic [TW-1:0]      out_tag
);
   logic          v_ff   [QW+1];
   logic [NW-1:0] rem_ff [QW+1];
   logic [DW-1:0] den_ff [QW+1];
   logic [QW-1:0] q_ff   [QW+1];
   logic [TW-1:0] tag_ff [QW+1];

   logic [NW+DW-1:0] shifted [QW];
   logic             take    [QW];

   always_comb begin
      for (int s = 0; s < QW; s++) begin
         shifted[s] = (NW+DW)'(den_ff[s]) << (QW - 1 - s);
         take[s]    = (NW+DW)'(rem_ff[s]) >= shifted[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QW; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int s = 0; s < QW; s++) v_ff[s+1] <= v_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= in_num;
         den_ff[0] <= in_den;
         q_ff[0]   <= '0;
         tag_ff[0] <= in_tag;
         for (int s = 0; s < QW; s++) begin
            rem_ff[s+1] <= take[s] ? NW'((NW+DW)'(rem_ff[s]) - shifted[s]) : rem_ff[s];
            q_ff[s+1]   <= q_ff[s] | (QW'(take[s]) << (QW - 1 - s));
            den_ff[s+1] <= den_ff[s];
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign out_quot  = q_ff[QW];
   assign out_tag   = tag_ff[QW];
endmodule
`default_nettype wire

// File: hdl/chassis_power_current_limiter_top.sv
`default_nettype none
// Pipeline: one word accepted per cycle while the pipeline is not stalled.
// Path from accept to result valid: input stage, limit-select stage,
// 18-stage limit divider, sum stage, product stage, 18-stage scale dividers,
// output register. The pipeline moves only when the output register is free
// or being emptied. Synchronous reset clears all valid bits and sets the
// warning level to 1 and power_limit_w to 80.
module chassis_power_current_limiter_top #(
   parameter int MOTOR_COUNT = cpcl_pkg::MotorCountDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write_en,
   input  wire logic [cpcl_pkg::CsrAddrWidth-1:0] csr_index,
   input  wire logic [cpcl_pkg::CsrDataWidth-1:0] csr_data,
   cpcl_req_if.sink   req,
   cpcl_rsp_if.source rsp
);
   import cpcl_pkg::*;
   localparam int SumW = CmdWidth + $clog2(MOTOR_COUNT + 1);
   localparam int CmdBits = MOTOR_COUNT * CmdWidth;
   localparam int Tag1W = 17 + CmdBits;

   logic [1:0] warn_level_ff;
   logic [7:0] power_limit_w_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         warn_level_ff    <= 2'd1;
         power_limit_w_ff <= 8'd80;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WARN_LEVEL:    warn_level_ff    <= csr_data[1:0];
            CSR_POWER_LIMIT_W: power_limit_w_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   logic out_v_ff, en;
   assign en = !out_v_ff || rsp.ready;
   assign req.ready = en;

   // Stage A: register the word, pack commands.
   logic                a_v_ff, a_ok_ff;
   logic [13:0]         a_p_ff;
   logic [7:0]          a_buf_ff;
   logic [CmdBits-1:0]  a_cmd_ff;
   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (en) a_v_ff <= req.valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         a_ok_ff  <= req.referee_ok;
         a_p_ff   <= req.chassis_power_q6;
         a_buf_ff <= req.buffer_energy;
         for (int i = 0; i < MOTOR_COUNT; i++)
            a_cmd_ff[i*CmdWidth +: CmdWidth] <= req.motor_cmd[i];
      end
   end

   // Stage B: pick the limit case and form numerator and denominator.
   // Fixed cases go through the divider as base + num/1.
   logic [13:0] warn_q6, lim_q6;
   logic [7:0]  buf_c;
   logic [31:0] b_num_in;
   logic [19:0] b_den_in;
   logic [16:0] b_base_in;
   assign warn_q6 = {warn_power(warn_level_ff), 6'd0};
   assign lim_q6  = {power_limit_w_ff, 6'd0};
   assign buf_c   = (a_buf_ff > MIN_BUFFER_J) ? a_buf_ff : MIN_BUFFER_J;
   always_comb begin
      b_num_in  = '0;
      b_den_in  = 20'd1;
      b_base_in = '0;
      if (!a_ok_ff) begin
         b_base_in = LIMIT_NO_REFEREE;
      end else if (a_buf_ff < WARN_BUFFER_J) begin
         b_num_in = 32'(LIMIT_BUFFER) * 32'(buf_c);
         b_den_in = 20'(WARN_BUFFER_J);
      end else if (a_p_ff > warn_q6) begin
         b_base_in = LIMIT_BUFFER;
         if (a_p_ff < lim_q6) begin
            b_num_in = 32'(LIMIT_POWER) * 32'(lim_q6 - a_p_ff);
            b_den_in = 20'(lim_q6 - warn_q6);
         end
      end else begin
         b_base_in = LIMIT_BUFFER + LIMIT_POWER;
      end
   end
   logic               b_v_ff;
   logic [31:0]        b_num_ff;
   logic [19:0]        b_den_ff;
   logic [16:0]        b_base_ff;
   logic [CmdBits-1:0] b_cmd_ff;
   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (en) b_v_ff <= a_v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         b_num_ff  <= b_num_in;
         b_den_ff  <= b_den_in;
         b_base_ff <= b_base_in;
         b_cmd_ff  <= a_cmd_ff;
      end
   end

   logic             d1_v;
   logic [16:0]      d1_q;
   logic [Tag1W-1:0] d1_tag;
   cpcl_div #(.NW(32), .DW(20), .QW(17), .TW(Tag1W)) u_div_limit (
      .clock, .reset, .en,
      .in_valid (b_v_ff), .in_num (b_num_ff), .in_den (b_den_ff),
      .in_tag   ({b_base_ff, b_cmd_ff}),
      .out_valid(d1_v), .out_quot(d1_q), .out_tag(d1_tag)
   );

   // Stage C: final limit, magnitudes and their sum.
   logic [16:0]        c_lim_in;
   logic [SumW-1:0]    c_sum_in;
   logic [CmdWidth-1:0] c_mag_in [MOTOR_COUNT];
   logic [MOTOR_COUNT-1:0] c_neg_in;
   assign c_lim_in = 17'(d1_tag[CmdBits +: 17] + d1_q);
   always_comb begin
      c_sum_in = '0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         c_neg_in[i] = d1_tag[i*CmdWidth + CmdWidth - 1];
         c_mag_in[i] = c_neg_in[i] ? CmdWidth'(-d1_tag[i*CmdWidth +: CmdWidth])
                                   : d1_tag[i*CmdWidth +: CmdWidth];
         c_sum_in = SumW'(c_sum_in + SumW'(c_mag_in[i]));
      end
   end
   logic                   c_v_ff;
   logic [16:0]            c_lim_ff;
   logic [SumW-1:0]        c_sum_ff;
   logic [CmdWidth-1:0]    c_mag_ff [MOTOR_COUNT];
   logic [MOTOR_COUNT-1:0] c_neg_ff;
   logic [CmdBits-1:0]     c_cmd_ff;
   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else if (en) c_v_ff <= d1_v;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         c_lim_ff <= c_lim_in;
         c_sum_ff <= c_sum_in;
         c_mag_ff <= c_mag_in;
         c_neg_ff <= c_neg_in;
         c_cmd_ff <= d1_tag[CmdBits-1:0];
      end
   end

   // Stage D: one product per motor, then a divider per motor.
   logic               e_scale;
   logic [31:0]        d_prod_ff [MOTOR_COUNT];
   logic               d_v_ff, d_scale_ff;
   logic [16:0]        d_lim_ff;
   logic [SumW-1:0]    d_sum_ff;
   logic [MOTOR_COUNT-1:0] d_neg_ff;
   logic [CmdBits-1:0] d_cmd_ff;
   assign e_scale = 32'(c_sum_ff) > 32'(c_lim_ff);
   always_ff @(posedge clock) begin
      if (reset) d_v_ff <= 1'b0;
      else if (en) d_v_ff <= c_v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < MOTOR_COUNT; i++)
            d_prod_ff[i] <= 32'(c_mag_ff[i]) * 32'(c_lim_ff);
         d_scale_ff <= e_scale;
         d_lim_ff   <= c_lim_ff;
         d_sum_ff   <= c_sum_ff;
         d_neg_ff   <= c_neg_ff;
         d_cmd_ff   <= c_cmd_ff;
      end
   end

   localparam int Tag2W = 1 + 17 + MOTOR_COUNT + CmdBits;
   logic [MOTOR_COUNT-1:0] s_v;
   logic [16:0]            s_q [MOTOR_COUNT];
   logic [Tag2W-1:0]       s_tag;
   for (genvar i = 0; i < MOTOR_COUNT; i++) begin : g_scale
      logic [Tag2W-1:0] tag_o;
      cpcl_div #(.NW(32), .DW(SumW), .QW(17), .TW(Tag2W)) u_div (
         .clock, .reset, .en,
         .in_valid (d_v_ff), .in_num (d_prod_ff[i]),
         .in_den   ((d_sum_ff == '0) ? SumW'(1) : d_sum_ff),
         .in_tag   ({d_scale_ff, d_lim_ff, d_neg_ff, d_cmd_ff}),
         .out_valid(s_v[i]), .out_quot(s_q[i]), .out_tag(tag_o)
      );
      if (i == 0) begin : g_tag
         assign s_tag = tag_o;
      end
   end

   // Output register.
   logic signed [CmdWidth-1:0] drive_ff [MOTOR_COUNT];
   logic [LimitWidth-1:0]      lim_out_ff;
   logic                       scaled_ff;
   logic                       f_scale;
   assign f_scale = s_tag[Tag2W-1];
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (en) out_v_ff <= s_v[0];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            if (f_scale)
               drive_ff[i] <= s_tag[CmdBits + i] ? CmdWidth'(-s_q[i][CmdWidth-1:0])
                                                 : s_q[i][CmdWidth-1:0];
            else
               drive_ff[i] <= s_tag[i*CmdWidth +: CmdWidth];
         end
         lim_out_ff <= s_tag[CmdBits + MOTOR_COUNT +: LimitWidth];
         scaled_ff  <= f_scale;
      end
   end
   assign rsp.valid         = out_v_ff;
   assign rsp.drive         = drive_ff;
   assign rsp.current_limit = lim_out_ff;
   assign rsp.was_scaled    = scaled_ff;
endmodule
`default_nettype wire
